// ----- rtl/core/plint_pkg.sv -----
// ----------------------------------------------------------------------------
// plint_pkg
// Shared constants and types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package plint_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DATA_W     = 32;
    localparam int KI_W       = 6;
    localparam int PC_W       = 7;
    localparam int MS_W       = 31;
    localparam int EM_W       = 16;
    localparam int CFG_A_W    = 2;
    localparam int CFG_D_W    = 31;
    localparam int DIVD_W     = 64;

    localparam logic [CFG_A_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_SLOPE   = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_END_MARGIN  = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIVI_GO,
        ST_DIVI,
        ST_DIVS_GO,
        ST_DIVS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ----- rtl/core/plint_cell.sv -----
// ----------------------------------------------------------------------------
// plint_cell
// One knot of the table; takes its neighbor's knot when the chain rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module plint_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic                             i_shift,
    input  wire logic signed [plint_pkg::DATA_W-1:0] i_load_x,
    input  wire logic signed [plint_pkg::DATA_W-1:0] i_load_y,
    input  wire logic signed [plint_pkg::DATA_W-1:0] i_next_x,
    input  wire logic signed [plint_pkg::DATA_W-1:0] i_next_y,
    output logic signed      [plint_pkg::DATA_W-1:0] o_x,
    output logic signed      [plint_pkg::DATA_W-1:0] o_y
);

    logic signed [plint_pkg::DATA_W-1:0] r_x;
    logic signed [plint_pkg::DATA_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end else if (i_we) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

// ----- rtl/core/plint_div.sv -----
// ----------------------------------------------------------------------------
// plint_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plint_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire plint_pkg::t_div_req             i_req,
    output logic [plint_pkg::DIVD_W-1:0]         o_quo,
    output logic                                 o_done
);

    localparam int CW = $clog2(plint_pkg::DIVD_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [plint_pkg::DATA_W-1:0]  r_rem;
    logic [plint_pkg::DATA_W-1:0]  r_dvs;
    logic [plint_pkg::DIVD_W-1:0]  r_quo;
    logic [plint_pkg::DATA_W:0]    w_sh;
    logic [plint_pkg::DATA_W:0]    w_diff;
    logic                          w_ge;

    assign w_sh   = {r_rem, r_quo[plint_pkg::DIVD_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(plint_pkg::DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[plint_pkg::DATA_W-1:0] : w_sh[plint_pkg::DATA_W-1:0];
            r_quo <= {r_quo[plint_pkg::DIVD_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/core/piecewise_linear_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Knot table with linear interpolation and local slope, signed Q16.16.
// ----------------------------------------------------------------------------
// Knots sit in a row of cells that rotates one place per cycle past a single
// bracketing stage. A load transfer writes one cell. A query takes, from its
// transfer to the next accepted transfer, one full rotation of the cell row,
// a shift-add multiply and two passes of the shared restoring divider, plus
// control states; its result is presented in the same cycle in which the
// input is ready again, and a stalled output holds the query in its final
// state until the output register is free. One query is in work at a time; a
// finished result waits in the output register while the next transfer is
// taken. Knot entries read by a query must have been loaded first; there is
// no clearing pass.
`default_nettype none

module piecewise_linear_interpolator_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_addr,
    input  wire logic [30:0]                 i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // knot_index, knot_x_in, knot_y_in, query_x, 2 zero bits
    input  wire logic [103:0]                s_axis_tdata,
    // req_type
    input  wire logic                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // interp_value, slope_value
    output logic [63:0]                      m_axis_tdata,
    // slope_saturated
    output logic                             m_axis_tuser
);

    localparam int N  = plint_pkg::MAX_POINTS;
    localparam int IW = plint_pkg::IDX_W;
    localparam int DW = plint_pkg::DATA_W;

    plint_pkg::t_state r_state, n_state;

    logic [plint_pkg::PC_W-1:0] r_point_count;
    logic [plint_pkg::MS_W-1:0] r_max_slope;
    logic [plint_pkg::EM_W-1:0] r_end_margin;

    logic signed [DW-1:0] w_cx [N];
    logic signed [DW-1:0] w_cy [N];
    logic                 w_shift;
    logic                 w_load;

    logic [IW-1:0]        r_cnt;
    logic [IW-1:0]        r_last;
    logic [4:0]           r_bit;
    logic signed [DW-1:0] r_q, r_xf, r_yf, r_xl, r_yl, r_x0, r_y0, r_x1, r_y1;
    logic                 r_found;
    logic [DW-1:0]        r_num, r_den;
    logic [DW:0]          r_mag;
    logic                 r_neg, r_hi_out, r_lo_out, r_coinc, r_near;
    logic signed [DW-1:0] r_avg;
    logic [63:0]          r_prod;
    logic [DW:0]          r_corr;
    logic [63:0]          r_squo;

    logic                 r_m_valid;
    logic [63:0]          r_m_data;
    logic                 r_m_user;

    plint_pkg::t_div_req  w_div_req;
    logic [63:0]          w_div_quo;
    logic                 w_div_done;

    logic signed [DW-1:0] w_hx, w_hy;
    logic                 w_le, w_ge;
    logic signed [DW+1:0] w_q34, w_xl34, w_xf34, w_m34;
    logic signed [DW:0]   w_dy, w_sum;
    logic [DW+1:0]        w_y0p, w_y0m;
    logic signed [DW-1:0] w_iv, w_sv;
    logic                 w_sat, w_big;
    logic                 w_out_load;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 7'd2;
            r_max_slope   <= 31'h7fff_ffff;
            r_end_margin  <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                plint_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_wdata[plint_pkg::PC_W-1:0];
                plint_pkg::CFG_MAX_SLOPE:   r_max_slope   <= i_cfg_wdata[plint_pkg::MS_W-1:0];
                plint_pkg::CFG_END_MARGIN:  r_end_margin  <= i_cfg_wdata[plint_pkg::EM_W-1:0];
                default: ;
            endcase
        end
    end

    // cell row, rotating toward cell 0
    assign w_load = s_axis_tvalid && s_axis_tready && (s_axis_tuser == plint_pkg::REQ_LOAD);

    for (genvar g = 0; g < N; g++) begin : g_cell
        plint_cell u_cell (
            .i_clk    (i_clk),
            .i_we     (w_load && (32'(s_axis_tdata[plint_pkg::KI_W-1:0]) == g)),
            .i_shift  (w_shift),
            .i_load_x (s_axis_tdata[37:6]),
            .i_load_y (s_axis_tdata[69:38]),
            .i_next_x (w_cx[(g + 1) % N]),
            .i_next_y (w_cy[(g + 1) % N]),
            .o_x      (w_cx[g]),
            .o_y      (w_cy[g])
        );
    end

    assign w_hx = w_cx[0];
    assign w_hy = w_cy[0];
    assign w_le = w_hx <= r_q;
    assign w_ge = w_hx >= r_q;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plint_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tuser == plint_pkg::REQ_QUERY) begin
                    n_state = plint_pkg::ST_SCAN;
                end
            plint_pkg::ST_SCAN:
                if (r_cnt == IW'(N - 1)) begin
                    n_state = plint_pkg::ST_PREP;
                end
            plint_pkg::ST_PREP:    n_state = plint_pkg::ST_MUL;
            plint_pkg::ST_MUL:
                if (r_bit == 5'd0) begin
                    n_state = plint_pkg::ST_DIVI_GO;
                end
            plint_pkg::ST_DIVI_GO: n_state = plint_pkg::ST_DIVI;
            plint_pkg::ST_DIVI:
                if (w_div_done) begin
                    n_state = plint_pkg::ST_DIVS_GO;
                end
            plint_pkg::ST_DIVS_GO: n_state = plint_pkg::ST_DIVS;
            plint_pkg::ST_DIVS:
                if (w_div_done) begin
                    n_state = plint_pkg::ST_DONE;
                end
            plint_pkg::ST_DONE:
                if (!r_m_valid || m_axis_tready) begin
                    n_state = plint_pkg::ST_IDLE;
                end
            default: n_state = plint_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_axis_tready      = r_state == plint_pkg::ST_IDLE;
        w_shift            = r_state == plint_pkg::ST_SCAN;
        w_out_load         = (r_state == plint_pkg::ST_DONE) && (!r_m_valid || m_axis_tready);
        w_div_req.start    = (r_state == plint_pkg::ST_DIVI_GO) ||
                             (r_state == plint_pkg::ST_DIVS_GO);
        w_div_req.divisor  = r_den;
        w_div_req.dividend = (r_state == plint_pkg::ST_DIVI_GO) ? r_prod :
                             {15'd0, r_mag, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plint_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    plint_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );

    // preparation arithmetic
    assign w_q34  = {{2{r_q[DW-1]}}, r_q};
    assign w_xl34 = {{2{r_xl[DW-1]}}, r_xl};
    assign w_xf34 = {{2{r_xf[DW-1]}}, r_xf};
    assign w_m34  = {18'd0, r_end_margin};
    assign w_dy   = {r_y1[DW-1], r_y1} - {r_y0[DW-1], r_y0};
    assign w_sum  = {r_y0[DW-1], r_y0} + {r_y1[DW-1], r_y1};

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            plint_pkg::ST_IDLE: begin
                r_q   <= s_axis_tdata[101:70];
                r_cnt <= '0;
                if (r_point_count == '0) begin
                    r_last <= '0;
                end else if (32'(r_point_count) > N) begin
                    r_last <= IW'(N - 1);
                end else begin
                    r_last <= IW'(32'(r_point_count) - 1);
                end
            end
            plint_pkg::ST_SCAN: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    r_xf    <= w_hx;
                    r_yf    <= w_hy;
                    r_x0    <= w_hx;
                    r_y0    <= w_hy;
                    r_found <= w_ge;
                    if (w_ge || r_last == '0) begin
                        r_x1 <= w_hx;
                        r_y1 <= w_hy;
                    end
                end else if (r_cnt <= r_last) begin
                    if (w_le) begin
                        r_x0 <= w_hx;
                        r_y0 <= w_hy;
                    end
                    if (!r_found && (w_ge || r_cnt == r_last)) begin
                        r_x1    <= w_hx;
                        r_y1    <= w_hy;
                        r_found <= 1'b1;
                    end
                end
                if (r_cnt == r_last) begin
                    r_xl <= w_hx;
                    r_yl <= w_hy;
                end
            end
            plint_pkg::ST_PREP: begin
                r_num    <= DW'(r_q - r_x0);
                r_den    <= DW'(r_x1 - r_x0);
                r_neg    <= w_dy[DW];
                r_mag    <= w_dy[DW] ? DW'(0) - w_dy : w_dy;
                r_hi_out <= r_q > r_xl;
                r_lo_out <= r_q < r_xf;
                r_coinc  <= r_x1 <= r_x0;
                r_near   <= (w_q34 >= w_xl34 - w_m34) || (w_q34 <= w_xf34 + w_m34);
                r_avg    <= DW'((w_sum + {{DW{1'b0}}, w_sum[DW]}) >>> 1);
                r_prod   <= '0;
                r_bit    <= 5'd31;
            end
            plint_pkg::ST_MUL: begin
                r_prod <= (r_prod << 1) + (r_num[r_bit] ? {31'd0, r_mag} : 64'd0);
                r_bit  <= r_bit - 1'b1;
            end
            plint_pkg::ST_DIVI: if (w_div_done) r_corr <= w_div_quo[DW:0];
            plint_pkg::ST_DIVS: if (w_div_done) r_squo <= w_div_quo;
            default: ;
        endcase
    end

    // result assembly
    assign w_y0p = {{2{r_y0[DW-1]}}, r_y0} + {1'b0, r_corr};
    assign w_y0m = {{2{r_y0[DW-1]}}, r_y0} - {1'b0, r_corr};
    assign w_big = (r_squo[63:31] != '0) || (r_squo[30:0] > r_max_slope);

    always_comb begin
        priority if (r_hi_out) begin
            w_iv = r_yl;
        end else if (r_lo_out) begin
            w_iv = r_yf;
        end else if (r_coinc) begin
            w_iv = r_avg;
        end else begin
            w_iv = r_neg ? w_y0m[DW-1:0] : w_y0p[DW-1:0];
        end
        priority if (r_near) begin
            w_sv  = '0;
            w_sat = 1'b0;
        end else if (r_coinc) begin
            w_sv  = {1'b0, r_max_slope};
            w_sat = 1'b1;
        end else if (w_big) begin
            w_sv  = r_neg ? DW'(0) - {1'b0, r_max_slope} : {1'b0, r_max_slope};
            w_sat = 1'b1;
        end else begin
            w_sv  = r_neg ? DW'(0) - r_squo[DW-1:0] : r_squo[DW-1:0];
            w_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {w_sv, w_iv};
            r_m_user <= w_sat;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == plint_pkg::ST_DIVI || r_state == plint_pkg::ST_DIVS))
        else $error("divider finished outside a divide phase");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (m_axis_tvalid && r_state == plint_pkg::ST_IDLE))
        else $error("result not presented after completion");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plint_pkg::ST_SCAN && r_cnt != IW'(N - 1)) |=>
        (r_state == plint_pkg::ST_SCAN && r_cnt == IW'($past(r_cnt) + 1'b1)))
        else $error("rotation ended early");
`endif

endmodule

`default_nettype wire
